// ===== hdl/bfg_pkg.sv =====
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared widths, register codes, control structs and root constants for the
// gray bilateral filter.
// ----------------------------------------------------------------------------
package bfg_pkg;

   localparam int HALF_WIDTH_DEF = 2;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int IW_W       = 11;
   localparam int IH_W       = 13;
   localparam int COEF_W     = 24;
   localparam int INROW_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // window index and step counter, sized for HALF_WIDTH up to 7
   localparam int KIDX_W     = 4;
   localparam int CNT_W      = 5;
   localparam int ROOT_STEPS = 16;

   localparam logic [IW_W-1:0]   IW_RESET = IW_W'(512);
   localparam logic [IH_W-1:0]   IH_RESET = IH_W'(512);
   localparam logic [COEF_W-1:0] SC_RESET = COEF_W'(4194304);
   localparam logic [COEF_W-1:0] RC_RESET = COEF_W'(41943);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SPATIAL      = 2'd2,
      CSR_RANGE        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              accept;
      logic              load_rd;
      logic              load_cap;
      logic              shift;
      logic              ctr_cap;
      logic              elem_a;
      logic              elem_b;
      logic              root_step;
      logic              acc;
      logic              div_init;
      logic              div_step;
      logic              out_load;
      logic              advance;
      logic [KIDX_W-1:0] dr;
      logic [KIDX_W-1:0] dc;
      logic [CNT_W-1:0]  idx;
   } dp_cmd_type;

   typedef struct packed {
      logic ignore;
      logic emit;
      logic last_col;
      logic out_free;
   } dp_sts_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-(idx+1)) in Q0.32
   function automatic logic [31:0] root_value(input int idx);
      logic [63:0] r;
      r = isqrt64(64'h8000_0000_0000_0000);
      for (int i = 0; i < idx; i++) begin
         r = isqrt64(r << 32);
      end
      return r[31:0];
   endfunction

endpackage

// ===== hdl/bfg_req_if.sv =====
// ----------------------------------------------------------------------------
// bfg_req_if
// Input item channel: command and gray pixel.
// ----------------------------------------------------------------------------
interface bfg_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [bfg_pkg::PIX_W-1:0]   pixel;

   modport source (output valid, output command, output pixel, input ready);
   modport sink   (input valid, input command, input pixel, output ready);
endinterface

// ===== hdl/bfg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfg_rsp_if
// Result item channel: filtered pixel with its position and run flags.
// ----------------------------------------------------------------------------
interface bfg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfg_pkg::PIX_W-1:0]   filtered;
   logic [bfg_pkg::ROW_W-1:0]   out_row;
   logic [bfg_pkg::COL_W-1:0]   out_col;
   logic                        last_in_run;
   logic                        frame_done;

   modport source (output valid, output filtered, output out_row, output out_col,
                   output last_in_run, output frame_done, input ready);
   modport sink   (input valid, input filtered, input out_row, input out_col,
                   input last_in_run, input frame_done, output ready);
endinterface

// ===== hdl/bfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfg_ctrl
// Sequencer: line load, window shift, per-element weight loop, divide and
// result hand-off.
// ----------------------------------------------------------------------------
module bfg_ctrl #(
   parameter int HALF_WIDTH = bfg_pkg::HALF_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bfg_pkg::dp_sts_type  sts,
   output bfg_pkg::dp_cmd_type  cmd
);

   localparam int KSIZE = 2 * HALF_WIDTH + 1;
   localparam int SLOTS = 2 * HALF_WIDTH;
   localparam logic [bfg_pkg::KIDX_W-1:0] K_LAST = bfg_pkg::KIDX_W'(KSIZE - 1);
   localparam logic [bfg_pkg::KIDX_W-1:0] K_MID  = bfg_pkg::KIDX_W'(HALF_WIDTH);
   localparam logic [bfg_pkg::CNT_W-1:0]  LOAD_LAST = bfg_pkg::CNT_W'(SLOTS);
   localparam logic [bfg_pkg::CNT_W-1:0]  ROOT_LAST = bfg_pkg::CNT_W'(bfg_pkg::ROOT_STEPS - 1);
   localparam logic [bfg_pkg::CNT_W-1:0]  DIV_LAST  = bfg_pkg::CNT_W'(bfg_pkg::PIX_W);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_LOAD  = 12'b0000_0000_0010,
      ST_SHIFT = 12'b0000_0000_0100,
      ST_CTR   = 12'b0000_0000_1000,
      ST_ELA   = 12'b0000_0001_0000,
      ST_ELB   = 12'b0000_0010_0000,
      ST_ROOT  = 12'b0000_0100_0000,
      ST_ACC   = 12'b0000_1000_0000,
      ST_DIVI  = 12'b0001_0000_0000,
      ST_DIV   = 12'b0010_0000_0000,
      ST_OUT   = 12'b0100_0000_0000,
      ST_ADV   = 12'b1000_0000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [bfg_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [bfg_pkg::KIDX_W-1:0]   dr_ff, dr_in;
   logic [bfg_pkg::KIDX_W-1:0]   dc_ff, dc_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dr_in    = dr_ff;
      dc_in    = dc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !sts.ignore) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == LOAD_LAST) begin
               state_in = ST_SHIFT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            state_in = sts.emit ? ST_CTR : ST_ADV;
         end
         ST_CTR: begin
            dr_in    = '0;
            dc_in    = '0;
            state_in = ST_ELA;
         end
         ST_ELA: begin
            state_in = ST_ELB;
         end
         ST_ELB: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ACC: begin
            if (dc_ff == K_LAST) begin
               dc_in = '0;
               if (dr_ff == K_LAST) begin
                  state_in = ST_DIVI;
               end else begin
                  dr_in    = dr_ff + 1'b1;
                  state_in = ST_ELA;
               end
            end else begin
               dc_in    = dc_ff + 1'b1;
               state_in = ST_ELA;
            end
         end
         ST_DIVI: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               state_in = sts.last_col ? ST_ADV : ST_CTR;
            end
         end
         ST_ADV: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         dr_ff    <= '0;
         dc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dr_ff    <= dr_in;
         dc_ff    <= dc_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd     = '0;
      cmd.dr  = dr_ff;
      cmd.dc  = dc_ff;
      cmd.idx = cnt_ff;
      case (state_ff)
         ST_IDLE:  cmd.accept    = req_valid;
         ST_LOAD: begin
            cmd.load_rd  = (cnt_ff != LOAD_LAST);
            cmd.load_cap = (cnt_ff != '0);
         end
         ST_SHIFT: cmd.shift     = 1'b1;
         ST_CTR: begin
            cmd.ctr_cap = 1'b1;
            cmd.dr      = K_MID;
            cmd.dc      = K_MID;
         end
         ST_ELA:   cmd.elem_a    = 1'b1;
         ST_ELB:   cmd.elem_b    = 1'b1;
         ST_ROOT:  cmd.root_step = 1'b1;
         ST_ACC:   cmd.acc       = 1'b1;
         ST_DIVI:  cmd.div_init  = 1'b1;
         ST_DIV:   cmd.div_step  = 1'b1;
         ST_OUT:   cmd.out_load  = sts.out_free;
         ST_ADV:   cmd.advance   = 1'b1;
         default:  cmd.accept    = 1'b0;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !sts.ignore) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not start a line load");

   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && cnt_ff == ROOT_LAST) |=> (state_ff == ST_ACC))
      else $error("root loop did not end in accumulate");

   a_window_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && dr_ff == K_LAST && dc_ff == K_LAST) |=> (state_ff == ST_DIVI))
      else $error("window sweep did not end in divide");

endmodule

// ===== hdl/bfg_datapath.sv =====
// ----------------------------------------------------------------------------
// bfg_datapath
// Settings, position, line store, window, weight unit, accumulators,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module bfg_datapath #(
   parameter int HALF_WIDTH = bfg_pkg::HALF_WIDTH_DEF,
   parameter int MAX_WIDTH  = bfg_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bfg_pkg::dp_cmd_type               cmd,
   output bfg_pkg::dp_sts_type               sts,
   input  logic                              req_command,
   input  logic [bfg_pkg::PIX_W-1:0]         req_pixel,
   input  logic                              csr_we,
   input  logic [bfg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   bfg_rsp_if.source                         rsp_chan
);

   localparam int PW     = bfg_pkg::PIX_W;
   localparam int KSIZE  = 2 * HALF_WIDTH + 1;
   localparam int SLOTS  = 2 * HALF_WIDTH;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = CW + 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int KI_W   = $clog2(KSIZE);
   localparam int AW     = SLOT_W + CW;
   localparam int SUM_L  = $clog2(KSIZE * KSIZE);
   localparam int W_W    = 17;
   localparam int M_W    = 33;
   localparam int NUM_W  = PW + W_W + SUM_L;
   localparam int DEN_W  = W_W + SUM_L;
   localparam int REM_W  = NUM_W + 2;
   localparam int Q_W    = PW + 1;
   localparam int D2_W   = $clog2(2 * HALF_WIDTH * HALF_WIDTH + 1);
   localparam int SQ_W   = 2 * bfg_pkg::KIDX_W + 1;
   localparam int DSC_W  = D2_W + bfg_pkg::COEF_W;
   localparam int DF2_W  = 2 * PW;
   localparam int DRC_W  = DF2_W + bfg_pkg::COEF_W;
   localparam int Y_W    = ((DSC_W > DRC_W) ? DSC_W : DRC_W) + 1;
   localparam int N_W    = Y_W - 24;
   localparam int SW     = ((CW > bfg_pkg::INROW_W) ? CW : bfg_pkg::INROW_W) + 3;
   localparam int IRW    = bfg_pkg::INROW_W;

   // settings
   logic [bfg_pkg::IW_W-1:0]   iw_ff;
   logic [bfg_pkg::IH_W-1:0]   ih_ff;
   logic [bfg_pkg::COEF_W-1:0] sc_ff;
   logic [bfg_pkg::COEF_W-1:0] rc_ff;

   // position and frame state
   logic [IRW-1:0]    in_row_ff;
   logic [CW-1:0]     in_col_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              done_ff;
   logic [CW-1:0]     x_ff;
   logic [PW-1:0]     pix_ff;
   logic [CW-1:0]     c_ff;
   logic [CW-1:0]     c1_ff;

   logic [PW-1:0]     window_ff [KSIZE][KSIZE];
   logic [PW-1:0]     colbuf_ff [SLOTS];
   logic [PW-1:0]     line_mem  [SLOTS * (1 << CW)];
   logic [PW-1:0]     rd_data_ff;

   // weight and sum
   logic [PW-1:0]     ctr_ff;
   logic [PW-1:0]     p_ff;
   logic [DF2_W-1:0]  df2_ff;
   logic [DSC_W-1:0]  dsc_ff;
   logic [Y_W-1:0]    yexp_ff;
   logic [M_W-1:0]    m_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  dvs_ff;
   logic [Q_W-1:0]    q_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [PW-1:0]              filtered_ff;
   logic [bfg_pkg::ROW_W-1:0]  out_row_ff;
   logic [bfg_pkg::COL_W-1:0]  out_col_ff;
   logic                       last_ff;
   logic                       fd_ff;

   logic [31:0] root_tab [bfg_pkg::ROOT_STEPS];

   for (genvar g = 0; g < bfg_pkg::ROOT_STEPS; g++) begin : g_root
      localparam logic [31:0] RV = bfg_pkg::root_value(g);
      assign root_tab[g] = RV;
   end

   // effective frame size
   logic [WW-1:0]               w_eff;
   logic [bfg_pkg::IH_W-1:0]    h_eff;
   logic                        draining;
   logic [CW-1:0]               x_start;
   logic                        x_last;

   always_comb begin
      if (iw_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(iw_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(iw_ff);
      end
      if (ih_ff == '0) begin
         h_eff = bfg_pkg::IH_W'(1);
      end else if (int'(ih_ff) > bfg_pkg::MAX_HEIGHT) begin
         h_eff = bfg_pkg::IH_W'(bfg_pkg::MAX_HEIGHT);
      end else begin
         h_eff = ih_ff;
      end
   end

   assign draining = (in_row_ff >= h_eff);
   assign x_start  = (WW'(in_col_ff) >= w_eff) ? '0 : in_col_ff;
   assign x_last   = (WW'(x_ff) == w_eff - 1'b1);

   // centres to emit for this item
   logic          emit;
   logic [CW-1:0] c0;
   logic [CW-1:0] c1;

   always_comb begin
      emit = (in_row_ff >= IRW'(HALF_WIDTH)) &&
             (x_last || (x_ff >= CW'(HALF_WIDTH)));
      if (x_last) begin
         c0 = (x_ff >= CW'(HALF_WIDTH)) ? x_ff - CW'(HALF_WIDTH) : '0;
         c1 = x_ff;
      end else begin
         c0 = x_ff - CW'(HALF_WIDTH);
         c1 = x_ff - CW'(HALF_WIDTH);
      end
   end

   // line store address
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] rd_slot;

   always_comb begin
      slot_sum = (SLOT_W + 1)'(slot_ff) + (SLOT_W + 1)'(cmd.idx);
      if (slot_sum >= (SLOT_W + 1)'(SLOTS)) begin
         slot_sum = slot_sum - (SLOT_W + 1)'(SLOTS);
      end
      rd_slot = slot_sum[SLOT_W-1:0];
   end

   // masked window read
   logic signed [SW-1:0] a_s;
   logic signed [SW-1:0] b_s;
   logic signed [SW-1:0] ci_s;
   logic                 in_win;
   logic [PW-1:0]        rd_pix;

   always_comb begin
      a_s  = $signed(SW'(in_row_ff)) - $signed(SW'(SLOTS)) + $signed(SW'(cmd.dr));
      b_s  = $signed(SW'(c_ff)) + $signed(SW'(cmd.dc)) - $signed(SW'(HALF_WIDTH));
      ci_s = $signed(SW'(c_ff)) - $signed(SW'(x_ff)) + $signed(SW'(cmd.dc)) +
             $signed(SW'(HALF_WIDTH));
      in_win = (a_s >= 0) && (a_s < $signed(SW'(h_eff))) &&
               (b_s >= 0) && (b_s < $signed(SW'(w_eff))) &&
               (ci_s >= 0) && (ci_s <= $signed(SW'(SLOTS)));
      rd_pix = in_win ? window_ff[cmd.dr[KI_W-1:0]][ci_s[KI_W-1:0]] : '0;
   end

   // exponent terms
   logic [bfg_pkg::KIDX_W-1:0] dro;
   logic [bfg_pkg::KIDX_W-1:0] dco;
   logic [D2_W-1:0]            d2;
   logic [PW-1:0]              df;

   always_comb begin
      dro = (cmd.dr >= bfg_pkg::KIDX_W'(HALF_WIDTH)) ?
            cmd.dr - bfg_pkg::KIDX_W'(HALF_WIDTH) : bfg_pkg::KIDX_W'(HALF_WIDTH) - cmd.dr;
      dco = (cmd.dc >= bfg_pkg::KIDX_W'(HALF_WIDTH)) ?
            cmd.dc - bfg_pkg::KIDX_W'(HALF_WIDTH) : bfg_pkg::KIDX_W'(HALF_WIDTH) - cmd.dc;
      d2  = D2_W'(SQ_W'(dro) * SQ_W'(dro) + SQ_W'(dco) * SQ_W'(dco));
      df  = (rd_pix > ctr_ff) ? rd_pix - ctr_ff : ctr_ff - rd_pix;
   end

   // 2^-f root step
   logic [3:0]     root_idx;
   logic [64:0]    root_prod;
   logic [15:0]    f16;
   logic           f_bit;

   always_comb begin
      root_idx  = cmd.idx[3:0];
      root_prod = 65'(m_ff) * 65'(root_tab[root_idx]) + 65'h0_8000_0000;
      f16       = yexp_ff[23:8];
      f_bit     = f16[4'd15 - root_idx];
   end

   // Q1.16 weight
   logic [N_W-1:0] n_val;
   logic [5:0]     n_sh;
   logic [33:0]    w_sum;
   logic [W_W-1:0] wt;

   always_comb begin
      n_val = yexp_ff[Y_W-1:24];
      n_sh  = 6'(n_val[4:0]);
      w_sum = 34'(m_ff) + (34'd1 << (n_sh + 6'd15));
      if (n_val > N_W'(16)) begin
         wt = '0;
      end else begin
         wt = W_W'(w_sum >> (n_sh + 6'd16));
      end
   end

   logic [IRW-1:0] r_row;
   logic           fd_now;
   logic [WW-1:0]  x_next;

   assign r_row  = in_row_ff - IRW'(HALF_WIDTH);
   assign fd_now = (r_row == h_eff - 1'b1) && (WW'(c_ff) == w_eff - 1'b1);
   assign x_next = WW'(x_ff) + 1'b1;

   assign sts.ignore   = !draining && req_command;
   assign sts.emit     = emit;
   assign sts.last_col = (c_ff == c1_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_chan.ready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff        <= bfg_pkg::IW_RESET;
         ih_ff        <= bfg_pkg::IH_RESET;
         sc_ff        <= bfg_pkg::SC_RESET;
         rc_ff        <= bfg_pkg::RC_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         slot_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
               window_ff[i][j] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            case (bfg_pkg::csr_index_type'(csr_index))
               bfg_pkg::CSR_IMAGE_WIDTH:  iw_ff <= csr_wdata[bfg_pkg::IW_W-1:0];
               bfg_pkg::CSR_IMAGE_HEIGHT: ih_ff <= csr_wdata[bfg_pkg::IH_W-1:0];
               bfg_pkg::CSR_SPATIAL:      sc_ff <= csr_wdata[bfg_pkg::COEF_W-1:0];
               bfg_pkg::CSR_RANGE:        rc_ff <= csr_wdata[bfg_pkg::COEF_W-1:0];
               default:                   iw_ff <= iw_ff;
            endcase
            in_row_ff <= '0;
            in_col_ff <= '0;
            slot_ff   <= '0;
            done_ff   <= 1'b0;
            for (int i = 0; i < KSIZE; i++) begin
               for (int j = 0; j < KSIZE; j++) begin
                  window_ff[i][j] <= '0;
               end
            end
         end
         if (cmd.shift) begin
            for (int i = 0; i < KSIZE; i++) begin
               for (int j = 0; j < KSIZE - 1; j++) begin
                  window_ff[i][j] <= window_ff[i][j+1];
               end
            end
            for (int i = 0; i < KSIZE - 1; i++) begin
               window_ff[i][KSIZE-1] <= colbuf_ff[i];
            end
            window_ff[KSIZE-1][KSIZE-1] <= pix_ff;
         end
         if (cmd.out_load && fd_now) begin
            done_ff <= 1'b1;
         end
         if (cmd.advance) begin
            if (done_ff) begin
               in_row_ff <= '0;
               in_col_ff <= '0;
               slot_ff   <= '0;
               done_ff   <= 1'b0;
            end else if (x_next >= w_eff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
               slot_ff   <= (slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : slot_ff + 1'b1;
            end else begin
               in_col_ff <= x_next[CW-1:0];
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (cmd.load_rd) begin
         rd_data_ff <= line_mem[AW'({rd_slot, x_ff})];
      end
      if (cmd.shift) begin
         line_mem[AW'({slot_ff, x_ff})] <= pix_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff   <= x_start;
         pix_ff <= draining ? '0 : req_pixel;
      end
      if (cmd.load_cap) begin
         for (int k = 0; k < SLOTS - 1; k++) begin
            colbuf_ff[k] <= colbuf_ff[k+1];
         end
         colbuf_ff[SLOTS-1] <= rd_data_ff;
      end
      if (cmd.shift) begin
         c_ff  <= c0;
         c1_ff <= c1;
      end
      if (cmd.ctr_cap) begin
         ctr_ff <= rd_pix;
         num_ff <= '0;
         den_ff <= '0;
      end
      if (cmd.elem_a) begin
         p_ff   <= rd_pix;
         df2_ff <= DF2_W'(df) * DF2_W'(df);
         dsc_ff <= DSC_W'(d2) * DSC_W'(sc_ff);
      end
      if (cmd.elem_b) begin
         yexp_ff <= Y_W'(DRC_W'(df2_ff) * DRC_W'(rc_ff)) + Y_W'(dsc_ff);
         m_ff    <= M_W'(1) << 32;
      end
      if (cmd.root_step && f_bit) begin
         m_ff <= root_prod[64:32];
      end
      if (cmd.acc) begin
         num_ff <= num_ff + NUM_W'(NUM_W'(wt) * NUM_W'(p_ff));
         den_ff <= den_ff + DEN_W'(wt);
      end
      if (cmd.div_init) begin
         rem_ff <= REM_W'(num_ff) + REM_W'(den_ff >> 1);
         dvs_ff <= REM_W'(den_ff) << (Q_W - 1);
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_ff <= rem_ff - dvs_ff;
            q_ff   <= {q_ff[Q_W-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[Q_W-2:0], 1'b0};
         end
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.out_load) begin
         filtered_ff <= q_ff[Q_W-1] ? {PW{1'b1}} : q_ff[PW-1:0];
         out_row_ff  <= r_row[bfg_pkg::ROW_W-1:0];
         out_col_ff  <= bfg_pkg::COL_W'(c_ff);
         last_ff     <= (c_ff == c1_ff);
         fd_ff       <= fd_now;
         if (c_ff != c1_ff) begin
            c_ff <= c_ff + 1'b1;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.filtered    = filtered_ff;
   assign rsp_chan.out_row     = out_row_ff;
   assign rsp_chan.out_col     = out_col_ff;
   assign rsp_chan.last_in_run = last_ff;
   assign rsp_chan.frame_done  = fd_ff;

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> (den_ff != '0))
      else $error("weight sum is zero at divide");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten while held");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(filtered_ff)))
      else $error("held result changed before it was taken");

endmodule

// ===== hdl/bilateral_filter_gray_core.sv =====
// ----------------------------------------------------------------------------
// bilateral_filter_gray_core
// Up to HALF_WIDTH+1 results per input. The 16-step 2^-f multiply loop run
// for each window element sets the rate; one item is in flight at a time.
// Synchronous active-high reset clears position, window and result valid and
// loads the register defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module bilateral_filter_gray_core #(
   parameter int HALF_WIDTH = bfg_pkg::HALF_WIDTH_DEF,
   parameter int MAX_WIDTH  = bfg_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bfg_req_if.sink                           req_chan,
   bfg_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [bfg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bfg_pkg::dp_cmd_type cmd;
   bfg_pkg::dp_sts_type sts;

   bfg_ctrl #(
      .HALF_WIDTH (HALF_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfg_datapath #(
      .HALF_WIDTH (HALF_WIDTH),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_command (req_chan.command),
      .req_pixel   (req_chan.pixel),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_chan    (rsp_chan)
   );

endmodule
